>>> rtl/ps2mq_pkg.sv
// Shared types and constants for the PS/2 mouse packet event queue.
// No dependencies; every other file in rtl/ uses this package.
package ps2mq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int DELTA_WIDTH_DEF = 16;
    localparam int CMDQ_DEPTH      = 2;

    localparam logic [7:0] PKT_SYNC_MASK = 8'h08;
    localparam logic [7:0] PKT_OVF_MASK  = 8'hc0;
    localparam int         BTN_BITS      = 3;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_SUBMIT = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_READ    = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_REJECT  = 3'd4,
        ST_HELD    = 3'd5,
        ST_IGNORED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_PUSH   = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_status status;
    } t_cmd_ctl;

    localparam int CTL_W = $bits(t_cmd_ctl);

endpackage

>>> rtl/ps2_mouse_packet_event_queue.sv
// PS/2 mouse packet decoder with a motion event ring FIFO, top level.
// Depends on ps2mq_pkg, ps2mq_front, ps2mq_cmdq and ps2mq_back.
//
// Every beat pushed in yields exactly one result beat, in order. The front end
// frames aux bytes into 3-byte packets and classifies each beat in the cycle it
// is taken; a two-entry command queue sits behind it, so full rises only when
// the back end falls behind. The back end runs one command per cycle while the
// result register is free, except a read of a non-empty event FIFO, which goes
// through BK_RDWAIT because the event memory has a registered read port. The
// event FIFO holds QUEUE_DEPTH - 1 events and needs no clearing after reset. A
// result waits in the output register until popped, and the back end keeps
// going as soon as it is taken.
module ps2_mouse_packet_event_queue #(
    parameter int QUEUE_DEPTH = ps2mq_pkg::QUEUE_DEPTH_DEF,
    parameter int DELTA_WIDTH = ps2mq_pkg::DELTA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_aux_flag,
    input  logic [7:0]                    i_data_byte,
    input  logic signed [DELTA_WIDTH-1:0] i_motion_x,
    input  logic signed [DELTA_WIDTH-1:0] i_motion_y,
    input  logic [7:0]                    i_button_bits,
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    o_status,
    output logic signed [DELTA_WIDTH-1:0] o_out_dx,
    output logic signed [DELTA_WIDTH-1:0] o_out_dy,
    output logic [7:0]                    o_out_buttons
);

    localparam int PAY_W = 2 * DELTA_WIDTH + 8 + ps2mq_pkg::CTL_W;

    logic                   in_accept;
    ps2mq_pkg::t_cmd_ctl    fr_ctl;
    logic [DELTA_WIDTH-1:0] fr_dx;
    logic [DELTA_WIDTH-1:0] fr_dy;
    logic [7:0]             fr_btn;
    logic [PAY_W-1:0]       q_in;
    logic [PAY_W-1:0]       q_out;
    logic                   q_empty;
    logic                   cmd_take;
    ps2mq_pkg::t_cmd_ctl    bk_ctl;
    logic [DELTA_WIDTH-1:0] bk_dx;
    logic [DELTA_WIDTH-1:0] bk_dy;
    logic [7:0]             bk_btn;

    assign in_accept = push && !full;

    ps2mq_front #(
        .DELTA_WIDTH (DELTA_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_opcode      (i_opcode),
        .i_aux_flag    (i_aux_flag),
        .i_data_byte   (i_data_byte),
        .i_motion_x    (i_motion_x),
        .i_motion_y    (i_motion_y),
        .i_button_bits (i_button_bits),
        .o_ctl         (fr_ctl),
        .o_dx          (fr_dx),
        .o_dy          (fr_dy),
        .o_btn         (fr_btn)
    );

    assign q_in = {fr_dx, fr_dy, fr_btn, fr_ctl};

    ps2mq_cmdq #(
        .DATA_W (PAY_W),
        .DEPTH  (ps2mq_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (cmd_take),
        .o_empty (q_empty),
        .i_data  (q_in),
        .o_data  (q_out)
    );

    assign {bk_dx, bk_dy, bk_btn, bk_ctl} = q_out;

    ps2mq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DELTA_WIDTH (DELTA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .o_cmd_take  (cmd_take),
        .i_ctl       (bk_ctl),
        .i_dx        (bk_dx),
        .i_dy        (bk_dy),
        .i_btn       (bk_btn),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_status    (o_status),
        .o_dx        (o_out_dx),
        .o_dy        (o_out_dy),
        .o_btn       (o_out_buttons)
    );

endmodule

>>> rtl/ps2mq_front.sv
// Front end: packet framing of aux bytes and opcode classification.
// Depends on ps2mq_pkg; feeds the command queue.
module ps2mq_front #(
    parameter int DELTA_WIDTH = ps2mq_pkg::DELTA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [1:0]                 i_opcode,
    input  logic                       i_aux_flag,
    input  logic [7:0]                 i_data_byte,
    input  logic [DELTA_WIDTH-1:0]     i_motion_x,
    input  logic [DELTA_WIDTH-1:0]     i_motion_y,
    input  logic [7:0]                 i_button_bits,
    output ps2mq_pkg::t_cmd_ctl        o_ctl,
    output logic [DELTA_WIDTH-1:0]     o_dx,
    output logic [DELTA_WIDTH-1:0]     o_dy,
    output logic [7:0]                 o_btn
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic [7:0] r_held0;
    logic [7:0] n_held0;
    logic [7:0] r_held1;
    logic [7:0] n_held1;

    always_comb begin
        n_idx        = r_idx;
        n_held0      = r_held0;
        n_held1      = r_held1;
        o_ctl.kind   = ps2mq_pkg::KIND_STATUS;
        o_ctl.status = ps2mq_pkg::ST_IGNORED;
        o_dx         = i_motion_x;
        o_dy         = i_motion_y;
        o_btn        = i_button_bits;
        case (i_opcode)
            ps2mq_pkg::OP_BYTE: begin
                if (i_aux_flag) begin
                    if (r_idx == 2'd0) begin
                        n_held0      = i_data_byte;
                        n_idx        = 2'd1;
                        o_ctl.status = ps2mq_pkg::ST_HELD;
                    end else if (r_idx == 2'd1) begin
                        n_held1      = i_data_byte;
                        n_idx        = 2'd2;
                        o_ctl.status = ps2mq_pkg::ST_HELD;
                    end else begin
                        n_idx = 2'd0;
                        if ((r_held0 & ps2mq_pkg::PKT_SYNC_MASK) == 8'h00 ||
                            (r_held0 & ps2mq_pkg::PKT_OVF_MASK) != 8'h00) begin
                            o_ctl.status = ps2mq_pkg::ST_REJECT;
                        end else begin
                            o_ctl.kind = ps2mq_pkg::KIND_PUSH;
                            o_dx = {{(DELTA_WIDTH-8){r_held1[7]}}, r_held1};
                            o_dy = DELTA_WIDTH'(0) -
                                   {{(DELTA_WIDTH-8){i_data_byte[7]}}, i_data_byte};
                            o_btn = {{(8-ps2mq_pkg::BTN_BITS){1'b0}},
                                     r_held0[ps2mq_pkg::BTN_BITS-1:0]};
                        end
                    end
                end
            end
            ps2mq_pkg::OP_SUBMIT: begin
                o_ctl.kind = ps2mq_pkg::KIND_PUSH;
            end
            ps2mq_pkg::OP_READ: begin
                o_ctl.kind = ps2mq_pkg::KIND_READ;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (i_accept) begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

endmodule

>>> rtl/ps2mq_cmdq.sv
// Short command queue between front and back end.
// Depends on ps2mq_pkg for its default depth.
module ps2mq_cmdq #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = ps2mq_pkg::CMDQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/ps2mq_back.sv
// Back end: event ring FIFO memory, push/pop execution and result register.
// Depends on ps2mq_pkg; takes commands from the command queue.
module ps2mq_back #(
    parameter int QUEUE_DEPTH = ps2mq_pkg::QUEUE_DEPTH_DEF,
    parameter int DELTA_WIDTH = ps2mq_pkg::DELTA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_take,
    input  ps2mq_pkg::t_cmd_ctl    i_ctl,
    input  logic [DELTA_WIDTH-1:0] i_dx,
    input  logic [DELTA_WIDTH-1:0] i_dy,
    input  logic [7:0]             i_btn,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [2:0]             o_status,
    output logic [DELTA_WIDTH-1:0] o_dx,
    output logic [DELTA_WIDTH-1:0] o_dy,
    output logic [7:0]             o_btn
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        BK_RUN    = 2'b01,
        BK_RDWAIT = 2'b10
    } t_back_state;

    logic [DELTA_WIDTH-1:0] r_mem_dx  [QUEUE_DEPTH];
    logic [DELTA_WIDTH-1:0] r_mem_dy  [QUEUE_DEPTH];
    logic [7:0]             r_mem_btn [QUEUE_DEPTH];

    t_back_state            r_state,     n_state;
    logic [PTR_W-1:0]       r_wp,        n_wp;
    logic [PTR_W-1:0]       r_rp,        n_rp;
    logic                   r_out_valid, n_out_valid;
    ps2mq_pkg::t_status     r_status,    n_status;
    logic [DELTA_WIDTH-1:0] r_dx,        n_dx;
    logic [DELTA_WIDTH-1:0] r_dy,        n_dy;
    logic [7:0]             r_btn,       n_btn;
    logic [DELTA_WIDTH-1:0] r_rd_dx;
    logic [DELTA_WIDTH-1:0] r_rd_dy;
    logic [7:0]             r_rd_btn;

    logic             out_free;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_next;
    logic             q_full;
    logic             q_empty;
    logic             do_write;
    logic             do_read;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free   = !r_out_valid || i_pop;
    assign o_cmd_take = (r_state == BK_RUN) && i_cmd_valid && out_free;
    assign wp_next    = ptr_next(r_wp);
    assign rp_next    = ptr_next(r_rp);
    assign q_full     = (wp_next == r_rp);
    assign q_empty    = (r_rp == r_wp);
    assign do_write   = o_cmd_take && i_ctl.kind == ps2mq_pkg::KIND_PUSH && !q_full;
    assign do_read    = o_cmd_take && i_ctl.kind == ps2mq_pkg::KIND_READ && !q_empty;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_out_valid = r_out_valid && !i_pop;
        n_status    = r_status;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_btn       = r_btn;
        case (r_state)
            BK_RUN: begin
                if (o_cmd_take) begin
                    n_out_valid = 1'b1;
                    n_dx        = '0;
                    n_dy        = '0;
                    n_btn       = '0;
                    case (i_ctl.kind)
                        ps2mq_pkg::KIND_STATUS: begin
                            n_status = i_ctl.status;
                        end
                        ps2mq_pkg::KIND_PUSH: begin
                            if (q_full) begin
                                n_status = ps2mq_pkg::ST_FULL;
                            end else begin
                                n_status = ps2mq_pkg::ST_QUEUED;
                                n_wp     = wp_next;
                            end
                        end
                        ps2mq_pkg::KIND_READ: begin
                            if (q_empty) begin
                                n_status = ps2mq_pkg::ST_EMPTY;
                            end else begin
                                // data comes out of the memory next cycle
                                n_out_valid = 1'b0;
                                n_rp        = rp_next;
                                n_state     = BK_RDWAIT;
                            end
                        end
                        default: begin
                            n_status = ps2mq_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            BK_RDWAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ps2mq_pkg::ST_READ;
                    n_dx        = r_rd_dx;
                    n_dy        = r_rd_dy;
                    n_btn       = r_rd_btn;
                    n_state     = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_btn    <= n_btn;
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem_dx[r_wp]  <= i_dx;
            r_mem_dy[r_wp]  <= i_dy;
            r_mem_btn[r_wp] <= i_btn;
        end
        if (do_read) begin
            r_rd_dx  <= r_mem_dx[r_rp];
            r_rd_dy  <= r_mem_dy[r_rp];
            r_rd_btn <= r_mem_btn[r_rp];
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_status = r_status;
    assign o_dx     = r_dx;
    assign o_dy     = r_dy;
    assign o_btn    = r_btn;

endmodule

>>> rtl/ps2mq_checker.sv
// Port-level checker for ps2_mouse_packet_event_queue, bound to the top level.
// Depends on ps2mq_pkg and on the top-level port names.
module ps2mq_checker #(
    parameter int DELTA_WIDTH = ps2mq_pkg::DELTA_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [2:0]                    o_status,
    input logic signed [DELTA_WIDTH-1:0] o_out_dx,
    input logic signed [DELTA_WIDTH-1:0] o_out_dy,
    input logic [7:0]                    o_out_buttons
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !full && empty)
        else $error("queue not clear after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status != 3'd7)
        else $error("unused status code on result");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ps2mq_pkg::ST_READ) |->
        (o_out_dx == '0 && o_out_dy == '0 && o_out_buttons == 8'h00))
        else $error("nonzero payload on a result without event");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_out_dx) &&
                              $stable(o_out_dy) && $stable(o_out_buttons)))
        else $error("stalled result beat changed");

endmodule

bind ps2_mouse_packet_event_queue ps2mq_checker #(
    .DELTA_WIDTH (DELTA_WIDTH)
) u_checker (.*);
